>>> rtl/fbr_pkg.sv
package fbr_pkg;

  localparam int BLOCK_BYTES   = 16384;
  localparam int MAX_MSG_BYTES = 64;
  localparam int CNT_W         = $clog2(BLOCK_BYTES + 1);
  localparam int ADDR_W        = $clog2(BLOCK_BYTES);
  localparam int LEN_W         = $clog2(MAX_MSG_BYTES + 1);
  localparam int TMO_W         = 16;
  localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd2000;

  localparam int MAX_RESULTS   = 2;
  localparam int FIFO_DEPTH    = 8;
  localparam int FIFO_AW       = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW       = $clog2(FIFO_DEPTH + 1);
  // room kept for the item in the input register plus one more
  localparam int READY_LIMIT   = FIFO_DEPTH - 2 * MAX_RESULTS;

  localparam int IN_DATA_W     = 120;
  localparam int OUT_DATA_W    = 120;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_HDR   = 2'd1,
    KIND_DATA  = 2'd2,
    KIND_TICK  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    RESP_NONE    = 2'd0,
    RESP_NO_FILE = 2'd1,
    RESP_BAD_OFF = 2'd2,
    RESP_OTHER   = 2'd3
  } resp_err_t;

  typedef enum logic [1:0] {
    RES_WRITE = 2'd0,
    RES_REQ   = 2'd1,
    RES_DONE  = 2'd2,
    RES_ERR   = 2'd3
  } res_kind_t;

  typedef enum logic [1:0] {
    ERR_NO_FILE = 2'd0,
    ERR_BAD_OFF = 2'd1,
    ERR_HOST    = 2'd2,
    ERR_TIMEOUT = 2'd3
  } err_code_t;

  typedef struct packed {
    kind_t             kind;
    logic [31:0]       start_offset;
    resp_err_t         resp_error;
    logic [31:0]       resp_offset;
    logic [LEN_W-1:0]  resp_length;
    logic [31:0]       file_length;
    logic [7:0]        data_byte;
  } item_t;

  typedef struct packed {
    res_kind_t         result_kind;
    logic [ADDR_W-1:0] write_addr;
    logic [7:0]        write_byte;
    logic [31:0]       req_offset;
    logic [CNT_W-1:0]  req_length;
    logic [31:0]       file_size;
    logic [CNT_W-1:0]  received_count;
    err_code_t         error_code;
    logic              last;
  } res_t;

  typedef struct packed {
    logic push0;
    logic push1;
  } push_t;

endpackage

>>> rtl/firmware_block_reassembler.sv
// Channel   Direction  Handshake             Payload
// in_       slave      in_tvalid/in_tready   tuser = kind, tdata = item fields
// out_      master     out_tvalid/out_tready tuser = result_kind, tdata = result, tlast
// cfg_      write      cfg_wr_en             cfg_wr_data = timeout_ms
//
// One input transfer per cycle while in_tready is high: an item is registered in
// the input register, decoded against the block state in a single pass and leaves
// zero to two results in an eight-entry result queue that drives out_tvalid.
// in_tready depends only on queue fill and has no combinational path from out_tready;
// it drops only when the queue cannot take two more items' worth of results.
// Synchronous active-low reset idles the block and restores timeout_ms to 2000; no
// clearing pass is needed.
module firmware_block_reassembler (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata, from bit 0 up: start_offset[31:0], resp_error[1:0], resp_offset[31:0],
  // resp_length[6:0], file_length[31:0], data_byte[7:0], zero pad[6:0]
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [fbr_pkg::IN_DATA_W-1:0]   in_tdata,
  // in_tuser: kind[1:0]
  input  logic [1:0]                      in_tuser,
  // out_tdata, from bit 0 up: write_addr[13:0], write_byte[7:0], req_offset[31:0],
  // req_length[14:0], file_size[31:0], received_count[14:0], error_code[1:0],
  // zero pad[1:0]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [fbr_pkg::OUT_DATA_W-1:0]  out_tdata,
  // out_tuser: result_kind[1:0]
  output logic [1:0]                      out_tuser,
  output logic                            out_tlast,
  input  logic                            cfg_wr_en,
  input  logic [15:0]                     cfg_wr_data
);

  logic                        s1_valid_r;
  fbr_pkg::item_t              s1_item_r;
  fbr_pkg::item_t              in_item;
  fbr_pkg::push_t              push;
  fbr_pkg::res_t               res0, res1, head;
  logic                        q_not_empty;
  logic [fbr_pkg::FIFO_CW-1:0] q_count;
  logic                        pop;

  // unpack the input transfer
  always_comb begin
    in_item.kind         = fbr_pkg::kind_t'(in_tuser);
    in_item.start_offset = in_tdata[31:0];
    in_item.resp_error   = fbr_pkg::resp_err_t'(in_tdata[33:32]);
    in_item.resp_offset  = in_tdata[65:34];
    in_item.resp_length  = in_tdata[72:66];
    in_item.file_length  = in_tdata[104:73];
    in_item.data_byte    = in_tdata[112:105];
  end

  // reserve queue room for the registered item and the one being taken now
  assign in_tready = (q_count <= fbr_pkg::FIFO_CW'(fbr_pkg::READY_LIMIT));

  // input register: the item is always consumed in the following cycle
  always_ff @(posedge clk) begin
    if (!rst_n)
      s1_valid_r <= 1'b0;
    else
      s1_valid_r <= in_tvalid & in_tready;
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready)
      s1_item_r <= in_item;
  end

  fbr_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .item_valid (s1_valid_r),
    .item       (s1_item_r),
    .push       (push),
    .res0       (res0),
    .res1       (res1)
  );

  assign pop = out_tvalid & out_tready;

  fbr_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .res0     (res0),
    .res1     (res1),
    .pop      (pop),
    .head     (head),
    .not_empty(q_not_empty),
    .count    (q_count)
  );

  // pack the head result for the output transfer
  assign out_tvalid = q_not_empty;
  assign out_tuser  = head.result_kind;
  assign out_tlast  = head.last;
  assign out_tdata  = {2'b00, head.error_code, head.received_count, head.file_size,
                       head.req_length, head.req_offset, head.write_byte,
                       head.write_addr};

endmodule

>>> rtl/fbr_core.sv
module fbr_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [15:0]             cfg_wr_data,
  input  logic                    item_valid,
  input  fbr_pkg::item_t          item,
  output fbr_pkg::push_t          push,
  output fbr_pkg::res_t           res0,
  output fbr_pkg::res_t           res1
);

  localparam logic [fbr_pkg::CNT_W-1:0] BLK = fbr_pkg::CNT_W'(fbr_pkg::BLOCK_BYTES);
  localparam logic [fbr_pkg::LEN_W-1:0] MAXLEN = fbr_pkg::LEN_W'(fbr_pkg::MAX_MSG_BYTES);

  logic [fbr_pkg::TMO_W-1:0] timeout_r;
  logic [31:0]               block_start_r, block_start_nxt;
  logic [fbr_pkg::CNT_W-1:0] bytes_rcvd_r, bytes_rcvd_nxt;
  logic [fbr_pkg::TMO_W-1:0] wait_cnt_r, wait_cnt_nxt;
  logic [fbr_pkg::CNT_W-1:0] copy_ptr_r, copy_ptr_nxt;
  logic [fbr_pkg::LEN_W-1:0] copy_rem_r, copy_rem_nxt;
  logic [fbr_pkg::LEN_W-1:0] msg_rem_r, msg_rem_nxt;
  logic                      msg_acc_r, msg_acc_nxt;
  logic [31:0]               latched_len_r, latched_len_nxt;
  logic                      active_r, active_nxt;

  logic [fbr_pkg::LEN_W-1:0] rlen;
  logic [31:0]               rel;
  logic [fbr_pkg::CNT_W-1:0] room;
  logic                      wrote;

  function automatic fbr_pkg::res_t mk_req(input logic [31:0] off,
                                           input logic [fbr_pkg::CNT_W-1:0] len);
    fbr_pkg::res_t r;
    r = '0;
    r.result_kind = fbr_pkg::RES_REQ;
    r.req_offset  = off;
    r.req_length  = len;
    return r;
  endfunction

  function automatic fbr_pkg::res_t mk_err(input fbr_pkg::err_code_t code);
    fbr_pkg::res_t r;
    r = '0;
    r.result_kind = fbr_pkg::RES_ERR;
    r.error_code  = code;
    return r;
  endfunction

  function automatic fbr_pkg::res_t mk_done(input logic [31:0] fsize,
                                            input logic [fbr_pkg::CNT_W-1:0] cnt);
    fbr_pkg::res_t r;
    r = '0;
    r.result_kind    = fbr_pkg::RES_DONE;
    r.file_size      = fsize;
    r.received_count = cnt;
    return r;
  endfunction

  function automatic fbr_pkg::res_t mk_write(input logic [fbr_pkg::ADDR_W-1:0] addr,
                                             input logic [7:0] data);
    fbr_pkg::res_t r;
    r = '0;
    r.result_kind = fbr_pkg::RES_WRITE;
    r.write_addr  = addr;
    r.write_byte  = data;
    return r;
  endfunction

  // block is complete when full or when the file end is reached
  function automatic logic reached(input logic [fbr_pkg::CNT_W-1:0] cnt,
                                   input logic [31:0] flen,
                                   input logic [31:0] start);
    logic [31:0] to_end;
    to_end = flen - start;
    return (cnt == BLK) || (32'(cnt) >= to_end);
  endfunction

  function automatic fbr_pkg::err_code_t map_err(input fbr_pkg::resp_err_t e);
    fbr_pkg::err_code_t c;
    unique case (e)
      fbr_pkg::RESP_NO_FILE: c = fbr_pkg::ERR_NO_FILE;
      fbr_pkg::RESP_BAD_OFF: c = fbr_pkg::ERR_BAD_OFF;
      fbr_pkg::RESP_OTHER:   c = fbr_pkg::ERR_HOST;
      default:               c = fbr_pkg::ERR_TIMEOUT;
    endcase
    return c;
  endfunction

  always_comb begin
    block_start_nxt = block_start_r;
    bytes_rcvd_nxt  = bytes_rcvd_r;
    wait_cnt_nxt    = wait_cnt_r;
    copy_ptr_nxt    = copy_ptr_r;
    copy_rem_nxt    = copy_rem_r;
    msg_rem_nxt     = msg_rem_r;
    msg_acc_nxt     = msg_acc_r;
    latched_len_nxt = latched_len_r;
    active_nxt      = active_r;
    push            = '0;
    res0            = '0;
    res1            = '0;
    wrote           = 1'b0;
    rlen            = (item.resp_length > MAXLEN) ? MAXLEN : item.resp_length;
    rel             = item.resp_offset - block_start_r;
    room            = BLK - rel[fbr_pkg::CNT_W-1:0];

    if (item_valid) begin
      if (item.kind == fbr_pkg::KIND_START) begin
        block_start_nxt = item.start_offset;
        bytes_rcvd_nxt  = '0;
        wait_cnt_nxt    = '0;
        copy_ptr_nxt    = '0;
        copy_rem_nxt    = '0;
        msg_rem_nxt     = '0;
        msg_acc_nxt     = 1'b0;
        latched_len_nxt = '0;
        active_nxt      = 1'b1;
        res0            = mk_req(item.start_offset, BLK);
        push.push0      = 1'b1;
      end else if (active_r) begin
        unique case (item.kind)
          fbr_pkg::KIND_HDR: begin
            if (item.resp_error != fbr_pkg::RESP_NONE) begin
              res0         = mk_err(map_err(item.resp_error));
              push.push0   = 1'b1;
              active_nxt   = 1'b0;
              msg_rem_nxt  = '0;
              copy_rem_nxt = '0;
              msg_acc_nxt  = 1'b0;
            end else begin
              wait_cnt_nxt = '0;
              msg_rem_nxt  = rlen;
              if (item.resp_offset >= block_start_r && rel <= 32'(bytes_rcvd_r)) begin
                msg_acc_nxt     = 1'b1;
                latched_len_nxt = item.file_length;
                copy_ptr_nxt    = rel[fbr_pkg::CNT_W-1:0];
                copy_rem_nxt    = (fbr_pkg::CNT_W'(rlen) < room) ? rlen
                                                                  : room[fbr_pkg::LEN_W-1:0];
                if (rlen == '0 && reached(bytes_rcvd_r, item.file_length, block_start_r)) begin
                  res0         = mk_done(item.file_length, bytes_rcvd_r);
                  push.push0   = 1'b1;
                  active_nxt   = 1'b0;
                  msg_rem_nxt  = '0;
                  copy_rem_nxt = '0;
                  msg_acc_nxt  = 1'b0;
                end
              end else begin
                msg_acc_nxt  = 1'b0;
                copy_rem_nxt = '0;
              end
            end
          end
          fbr_pkg::KIND_DATA: begin
            if (msg_rem_r != '0) begin
              msg_rem_nxt = msg_rem_r - 1'b1;
              if (msg_acc_r && copy_rem_r != '0) begin
                wrote        = 1'b1;
                res0         = mk_write(copy_ptr_r[fbr_pkg::ADDR_W-1:0], item.data_byte);
                push.push0   = 1'b1;
                copy_ptr_nxt = copy_ptr_r + 1'b1;
                copy_rem_nxt = copy_rem_r - 1'b1;
                if (copy_ptr_nxt > bytes_rcvd_r)
                  bytes_rcvd_nxt = copy_ptr_nxt;
              end
              if (msg_rem_nxt == '0 && msg_acc_r) begin
                msg_acc_nxt  = 1'b0;
                copy_rem_nxt = '0;
                if (reached(bytes_rcvd_nxt, latched_len_r, block_start_r)) begin
                  active_nxt  = 1'b0;
                  msg_rem_nxt = '0;
                  if (wrote) begin
                    res1       = mk_done(latched_len_r, bytes_rcvd_nxt);
                    push.push1 = 1'b1;
                  end else begin
                    res0       = mk_done(latched_len_r, bytes_rcvd_nxt);
                    push.push0 = 1'b1;
                  end
                end
              end
            end
          end
          fbr_pkg::KIND_TICK: begin
            if (wait_cnt_r >= timeout_r) begin
              if (bytes_rcvd_r == '0) begin
                res0         = mk_err(fbr_pkg::ERR_TIMEOUT);
                active_nxt   = 1'b0;
                msg_rem_nxt  = '0;
                copy_rem_nxt = '0;
                msg_acc_nxt  = 1'b0;
              end else begin
                res0 = mk_req(block_start_r + 32'(bytes_rcvd_r), BLK - bytes_rcvd_r);
              end
              push.push0   = 1'b1;
              wait_cnt_nxt = '0;
            end else begin
              wait_cnt_nxt = wait_cnt_r + 1'b1;
            end
          end
          default: ;
        endcase
      end
    end

    if (push.push1)
      res1.last = 1'b1;
    else if (push.push0)
      res0.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r     <= fbr_pkg::TIMEOUT_RESET;
      block_start_r <= '0;
      bytes_rcvd_r  <= '0;
      wait_cnt_r    <= '0;
      copy_ptr_r    <= '0;
      copy_rem_r    <= '0;
      msg_rem_r     <= '0;
      msg_acc_r     <= 1'b0;
      latched_len_r <= '0;
      active_r      <= 1'b0;
    end else begin
      if (cfg_wr_en)
        timeout_r <= cfg_wr_data;
      block_start_r <= block_start_nxt;
      bytes_rcvd_r  <= bytes_rcvd_nxt;
      wait_cnt_r    <= wait_cnt_nxt;
      copy_ptr_r    <= copy_ptr_nxt;
      copy_rem_r    <= copy_rem_nxt;
      msg_rem_r     <= msg_rem_nxt;
      msg_acc_r     <= msg_acc_nxt;
      latched_len_r <= latched_len_nxt;
      active_r      <= active_nxt;
    end
  end

endmodule

>>> rtl/fbr_fifo.sv
module fbr_fifo (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fbr_pkg::push_t              push,
  input  fbr_pkg::res_t               res0,
  input  fbr_pkg::res_t               res1,
  input  logic                        pop,
  output fbr_pkg::res_t               head,
  output logic                        not_empty,
  output logic [fbr_pkg::FIFO_CW-1:0] count
);

  fbr_pkg::res_t               mem_r [fbr_pkg::FIFO_DEPTH];
  logic [fbr_pkg::FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [fbr_pkg::FIFO_AW-1:0] rd_ptr_r;
  logic [fbr_pkg::FIFO_CW-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + fbr_pkg::FIFO_AW'(push.push0) + fbr_pkg::FIFO_AW'(push.push1);
    count_nxt  = count_r + fbr_pkg::FIFO_CW'(push.push0) + fbr_pkg::FIFO_CW'(push.push1)
                 - fbr_pkg::FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.push0)
      mem_r[wr_ptr_r] <= res0;
    if (push.push1)
      mem_r[wr_ptr_r + 1'b1] <= res1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
      if (pop)
        rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

  assign head      = mem_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign count     = count_r;

endmodule

>>> rtl/fbr_checker.sv
module fbr_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [fbr_pkg::IN_DATA_W-1:0]   in_tdata,
  input logic [1:0]                      in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [fbr_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic [1:0]                      out_tuser,
  input logic                            out_tlast,
  input logic                            cfg_wr_en,
  input logic [15:0]                     cfg_wr_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // only a buffer write can be followed by another result of the same item
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == fbr_pkg::RES_REQ || out_tuser == fbr_pkg::RES_DONE ||
      out_tuser == fbr_pkg::RES_ERR) |-> out_tlast)
    else $error("non-write result without tlast");

  // a buffer write carries nothing beyond address and byte
  a_write_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == fbr_pkg::RES_WRITE |-> out_tdata[119:22] == '0)
    else $error("write result has stray fields");

  // reset empties the result queue
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind firmware_block_reassembler fbr_checker u_fbr_checker (.*);

>>> tb/sv/firmware_block_reassembler_tb.sv
`timescale 1ns / 100ps

module firmware_block_reassembler_tb;

  localparam int CLK_PERIOD    = 12;
  localparam int RESET_CYCLES  = 9;
  // input register plus result queue, with margin
  localparam int DRAIN_CYCLES  = 8;
  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_ITEMS   = 40;
  // ticks sent against a timeout too long to reach
  localparam int TICK_PROBE    = 20;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [fbr_pkg::IN_DATA_W-1:0]  in_tdata;
  logic [1:0]                     in_tuser;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [fbr_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [1:0]                     out_tuser;
  logic                           out_tlast;
  logic                           cfg_wr_en;
  logic [15:0]                    cfg_wr_data;

  firmware_block_reassembler dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Mirror of the block state, at reset values.
  logic [31:0]               blk_start  = '0;
  logic [fbr_pkg::CNT_W-1:0] bytes_in   = '0;
  logic [15:0]               idle_ticks = '0;
  logic [15:0]               tmo_limit  = fbr_pkg::TIMEOUT_RESET;
  logic [fbr_pkg::CNT_W-1:0] copy_ptr   = '0;
  logic [fbr_pkg::LEN_W-1:0] copy_left  = '0;
  logic [fbr_pkg::LEN_W-1:0] msg_left   = '0;
  logic                      msg_ok     = 1'b0;
  logic [31:0]               file_len   = '0;
  logic                      blk_active = 1'b0;

  // Results still owed by the block, oldest first; scratch for one item.
  fbr_pkg::res_t expected_results[$];
  fbr_pkg::res_t step_results[$];

  // Traffic shaping knobs; the receive-side ones are shared with the result sink.
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  int rx_hold_cycles = 0;

  int failures      = 0;
  int n_transfers   = 0;
  int n_effective   = 0;
  int n_results     = 0;
  int n_timeouts    = 0;
  int n_done        = 0;
  int n_errors      = 0;

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] random_offset();
    case ($urandom_range(0, 3))
      0:       return $urandom();
      1:       return 32'hFFFF_FFFF - $urandom_range(0, 300);
      2:       return $urandom_range(0, 300);
      default: return {16'($urandom_range(0, 65535)), 16'h0000};
    endcase
  endfunction

  function automatic fbr_pkg::res_t blank_result(fbr_pkg::res_kind_t k);
    fbr_pkg::res_t r;
    r = '0;
    r.result_kind = k;
    return r;
  endfunction

  // Go idle: drop the block and any message in progress.
  function automatic void close_block();
    blk_active = 1'b0;
    msg_left   = '0;
    copy_left  = '0;
    msg_ok     = 1'b0;
  endfunction

  // Emit done when the block is full or the file end has been reached.
  function automatic void finish_if_complete();
    fbr_pkg::res_t r;
    if (bytes_in == fbr_pkg::CNT_W'(fbr_pkg::BLOCK_BYTES) ||
        32'(bytes_in) >= file_len - blk_start) begin
      r = blank_result(fbr_pkg::RES_DONE);
      r.file_size      = file_len;
      r.received_count = bytes_in;
      step_results.push_back(r);
      n_done++;
      close_block();
    end
  endfunction

  // Advance the mirror by one accepted item and queue what it should produce.
  function automatic void reassemble_step(input fbr_pkg::item_t it);
    fbr_pkg::res_t             r;
    logic [31:0]               rel;
    logic [31:0]               room;
    logic [fbr_pkg::LEN_W-1:0] len;
    step_results.delete();
    if (it.kind == fbr_pkg::KIND_START || blk_active) n_effective++;

    if (it.kind == fbr_pkg::KIND_START) begin
      blk_start  = it.start_offset;
      bytes_in   = '0;
      idle_ticks = '0;
      copy_ptr   = '0;
      copy_left  = '0;
      msg_left   = '0;
      msg_ok     = 1'b0;
      file_len   = '0;
      blk_active = 1'b1;
      r = blank_result(fbr_pkg::RES_REQ);
      r.req_offset = it.start_offset;
      r.req_length = fbr_pkg::CNT_W'(fbr_pkg::BLOCK_BYTES);
      step_results.push_back(r);
    end else if (blk_active) begin
      case (it.kind)
        fbr_pkg::KIND_HDR: begin
          if (it.resp_error != fbr_pkg::RESP_NONE) begin
            r = blank_result(fbr_pkg::RES_ERR);
            case (it.resp_error)
              fbr_pkg::RESP_NO_FILE: r.error_code = fbr_pkg::ERR_NO_FILE;
              fbr_pkg::RESP_BAD_OFF: r.error_code = fbr_pkg::ERR_BAD_OFF;
              default:               r.error_code = fbr_pkg::ERR_HOST;
            endcase
            step_results.push_back(r);
            n_errors++;
            close_block();
          end else begin
            rel = it.resp_offset - blk_start;
            len = (it.resp_length > fbr_pkg::MAX_MSG_BYTES) ?
                  fbr_pkg::LEN_W'(fbr_pkg::MAX_MSG_BYTES) : it.resp_length;
            idle_ticks = '0;
            msg_left   = len;
            // accept only offsets inside what has already arrived (or its end)
            if (it.resp_offset >= blk_start && rel <= 32'(bytes_in)) begin
              room      = fbr_pkg::BLOCK_BYTES - rel;
              msg_ok    = 1'b1;
              file_len  = it.file_length;
              copy_ptr  = rel[fbr_pkg::CNT_W-1:0];
              copy_left = (32'(len) < room) ? len : fbr_pkg::LEN_W'(room);
              if (len == 0) finish_if_complete();
            end else begin
              msg_ok    = 1'b0;
              copy_left = '0;
            end
          end
        end
        fbr_pkg::KIND_DATA: begin
          if (msg_left != 0) begin
            msg_left--;
            if (msg_ok && copy_left != 0) begin
              r = blank_result(fbr_pkg::RES_WRITE);
              r.write_addr = copy_ptr[fbr_pkg::ADDR_W-1:0];
              r.write_byte = it.data_byte;
              step_results.push_back(r);
              copy_ptr++;
              copy_left--;
              if (copy_ptr > bytes_in) bytes_in = copy_ptr;
            end
            if (msg_left == 0 && msg_ok) begin
              msg_ok    = 1'b0;
              copy_left = '0;
              finish_if_complete();
            end
          end
        end
        default: begin
          if (idle_ticks >= tmo_limit) begin
            if (bytes_in == 0) begin
              r = blank_result(fbr_pkg::RES_ERR);
              r.error_code = fbr_pkg::ERR_TIMEOUT;
              step_results.push_back(r);
              n_errors++;
              close_block();
            end else begin
              // ask again for the missing tail
              r = blank_result(fbr_pkg::RES_REQ);
              r.req_offset = blk_start + 32'(bytes_in);
              r.req_length = fbr_pkg::CNT_W'(fbr_pkg::BLOCK_BYTES) - bytes_in;
              step_results.push_back(r);
            end
            idle_ticks = '0;
            n_timeouts++;
          end else begin
            idle_ticks++;
          end
        end
      endcase
    end

    if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
    foreach (step_results[i]) expected_results.push_back(step_results[i]);
  endfunction

  // Fill every field at random; callers override what the kind uses.
  function automatic fbr_pkg::item_t make_item(fbr_pkg::kind_t k);
    fbr_pkg::item_t it;
    it.kind         = k;
    it.start_offset = $urandom();
    it.resp_error   = fbr_pkg::resp_err_t'($urandom_range(0, 3));
    it.resp_offset  = $urandom();
    it.resp_length  = fbr_pkg::LEN_W'($urandom_range(0, 127));
    it.file_length  = $urandom();
    it.data_byte    = 8'($urandom_range(0, 255));
    return it;
  endfunction

  // Offer one item, hold it until the transfer, then maybe idle.
  task automatic send_item(input fbr_pkg::item_t it);
    int gap;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= it.kind;
    in_tdata  <= {7'd0, it.data_byte, it.file_length, it.resp_length,
                  it.resp_offset, it.resp_error, it.start_offset};
    do @(posedge clk); while (!in_tready);
    n_transfers++;
    reassemble_step(it);
    gap = tx_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk) in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_start(input logic [31:0] off);
    fbr_pkg::item_t it;
    it = make_item(fbr_pkg::KIND_START);
    it.start_offset = off;
    send_item(it);
  endtask

  task automatic send_header(input fbr_pkg::resp_err_t err, input logic [31:0] off,
                             input int len, input logic [31:0] flen);
    fbr_pkg::item_t it;
    it = make_item(fbr_pkg::KIND_HDR);
    it.resp_error  = err;
    it.resp_offset = off;
    it.resp_length = fbr_pkg::LEN_W'(len);
    it.file_length = flen;
    send_item(it);
  endtask

  task automatic send_data();
    send_item(make_item(fbr_pkg::KIND_DATA));
  endtask

  task automatic send_tick();
    send_item(make_item(fbr_pkg::KIND_TICK));
  endtask

  // Clean header followed by nbytes payload transfers.
  task automatic send_message(input logic [31:0] off, input int len, input int nbytes,
                              input logic [31:0] flen);
    send_header(fbr_pkg::RESP_NONE, off, len, flen);
    repeat (nbytes) send_data();
  endtask

  // Stop offering, let every owed result arrive, then allow the pipe to settle.
  task automatic wait_drained();
    @(negedge clk) in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk) cfg_wr_en <= 1'b0;
    tmo_limit = value;
  endtask

  task automatic tick_until_timeout();
    int seen;
    seen = n_timeouts;
    while (n_timeouts == seen) send_tick();
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Nothing but a start may produce anything while no block is open.
  task automatic test_idle_block();
    send_header(fbr_pkg::RESP_NONE, 32'h0, 4, 32'h0);
    send_header(fbr_pkg::RESP_OTHER, 32'h0, 0, 32'h0);
    send_data();
    send_tick();
  endtask

  // Open blocks at both ends of the offset range; the second start abandons the first.
  task automatic test_requests_and_restart();
    send_start(32'h0000_0000);
    send_start(32'hFFFF_FFFF);
    send_message(32'hFFFF_FFFF, 2, 2, 32'h0000_0000);
  endtask

  task automatic test_message_handling();
    logic [31:0] base;
    base = 32'h0000_1000;
    send_start(base);
    send_message(base, 4, 4, 32'hFFFF_FFFF);
    // overlap with bytes already held
    send_message(base + 2, 3, 3, 32'hFFFF_FFFF);
    // beyond the received edge: consume and drop
    send_message(base + 10, 2, 2, 32'hFFFF_FFFF);
    // no message pending
    send_data();
    // before the block start
    send_message(base - 1, 0, 0, 32'hFFFF_FFFF);
    // cut short by the next header, which is empty and reaches the file end
    send_message(base, 4, 1, 32'hFFFF_FFFF);
    send_message(base + 5, 0, 0, base + 5);
  endtask

  // Longest declared length saturates; the surplus bytes are strays.
  task automatic test_overlong_message();
    send_start(32'h0000_0100);
    send_message(32'h0000_0100, 127, fbr_pkg::MAX_MSG_BYTES + 2, 32'h0000_0100 + 32'd70);
    send_message(32'h0000_0100 + 32'd64, fbr_pkg::MAX_MSG_BYTES, fbr_pkg::MAX_MSG_BYTES,
                 32'h0000_0100 + 32'd70);
  endtask

  task automatic test_response_errors();
    send_start($urandom());
    send_header(fbr_pkg::RESP_NO_FILE, $urandom(), $urandom_range(0, 127), $urandom());
    send_start($urandom());
    send_header(fbr_pkg::RESP_BAD_OFF, $urandom(), $urandom_range(0, 127), $urandom());
    send_start($urandom());
    send_header(fbr_pkg::RESP_OTHER, $urandom(), $urandom_range(0, 127), $urandom());
  endtask

  // File end below the block start wraps and never completes; file end at the
  // start completes with nothing received.
  task automatic test_file_end();
    send_start(32'h8000_0000);
    send_message(32'h8000_0000, 0, 0, 32'h0000_1000);
    send_message(32'h8000_0000, 0, 0, 32'h8000_0000);
  endtask

  // Reset value of the timeout: a short run of ticks stays below it.
  task automatic test_default_timeout();
    send_start($urandom());
    repeat (TICK_PROBE) send_tick();
  endtask

  task automatic test_timeout_settings();
    logic [15:0] setting;
    logic [31:0] base;
    for (int i = 0; i < 4; i++) begin
      case (i)
        0:       setting = 16'd0;
        1:       setting = 16'd1;
        2:       setting = 16'd65535;
        default: setting = 16'($urandom_range(2, 12));
      endcase
      wait_drained();
      write_timeout(setting);
      send_start($urandom());
      if (setting == 16'd65535) begin
        // the widest setting is out of reach: ticks only count up
        repeat (TICK_PROBE) send_tick();
      end else begin
        while (blk_active) send_tick();
        base = $urandom_range(0, 32'h7FFF_FFFF);
        send_start(base);
        send_message(base, 5, 5, base + 32'h0100_0000);
        tick_until_timeout();
        send_tick();
        tick_until_timeout();
      end
    end
  endtask

  // Hold off the receiver while the sender streams, so the result queue fills
  // and in_tready drops.
  task automatic test_backpressure();
    wait_drained();
    tx_idle_en = 1'b0;
    rx_hold_cycles = 300;
    send_start(32'h0000_4000);
    send_message(32'h0000_4000, 40, 40, 32'hFFFF_FFFF);
    wait_drained();
    tx_idle_en = 1'b1;
  endtask

  task automatic test_random_traffic();
    int          target;
    int          roll;
    int          len;
    int          nbytes;
    logic [31:0] off;
    logic [31:0] flen;
    logic [15:0] setting;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       setting = 16'($urandom_range(0, 8));
        1:       setting = 16'd1;
        2:       setting = 16'd65535;
        3:       setting = 16'd0;
        default: setting = 16'($urandom_range(2, 40));
      endcase
      wait_drained();
      write_timeout(setting);
      // one phase runs with no idling on either side
      tx_idle_en = (phase != 1);
      rx_idle_en = (phase != 1);
      target = n_effective + PHASE_ITEMS;
      while (n_effective < target) begin
        if (!blk_active || $urandom_range(0, 49) == 0) send_start(random_offset());
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
          // well-formed message inside the window
          off = blk_start + $urandom_range(0, bytes_in);
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 127) : $urandom_range(0, 64);
          nbytes = (len > fbr_pkg::MAX_MSG_BYTES) ? fbr_pkg::MAX_MSG_BYTES : len;
          if ($urandom_range(0, 7) == 0) nbytes += $urandom_range(1, 3);
          flen = ($urandom_range(0, 2) == 0) ?
                 blk_start + 32'(bytes_in) + $urandom_range(0, 80) : $urandom();
          send_message(off, len, nbytes, flen);
        end else if (roll < 65) begin
          off = $urandom_range(0, 1) ? blk_start + 32'(bytes_in) + $urandom_range(1, 100)
                                     : blk_start - $urandom_range(1, 100);
          len = $urandom_range(0, 16);
          send_message(off, len, len, $urandom());
        end else if (roll < 72) begin
          // cut short, the next header drops the rest
          len = $urandom_range(2, 20);
          send_message(blk_start + $urandom_range(0, bytes_in), len,
                       $urandom_range(0, len - 1), $urandom());
        end else if (roll < 77) begin
          send_data();
        end else if (roll < 95) begin
          repeat ($urandom_range(1, 6)) send_tick();
        end else if (roll < 98) begin
          send_header(fbr_pkg::resp_err_t'($urandom_range(1, 3)), $urandom(),
                      $urandom_range(0, 127), $urandom());
        end else begin
          send_start(random_offset());
        end
      end
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off counted here on request.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int idle_left;
    idle_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        out_tready <= 1'b0;
        rx_hold_cycles--;
      end else if (idle_left > 0) begin
        out_tready <= 1'b0;
        idle_left--;
      end else begin
        out_tready <= 1'b1;
        if (rx_idle_en) idle_left = pick_gap();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result check: compare every transfer with the oldest owed result.
  // --------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      failures++;
      $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    fbr_pkg::res_t got;
    fbr_pkg::res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      got.result_kind    = fbr_pkg::res_kind_t'(out_tuser);
      got.write_addr     = out_tdata[13:0];
      got.write_byte     = out_tdata[21:14];
      got.req_offset     = out_tdata[53:22];
      got.req_length     = out_tdata[68:54];
      got.file_size      = out_tdata[100:69];
      got.received_count = out_tdata[115:101];
      got.error_code     = fbr_pkg::err_code_t'(out_tdata[117:116]);
      got.last           = out_tlast;
      if (expected_results.size() == 0) begin
        failures++;
        $display("%0t: unexpected result, expected none, actual kind %0d tdata 0x%0h",
                 $time, got.result_kind, out_tdata);
      end else begin
        want = expected_results.pop_front();
        check_field("result_kind", 32'(want.result_kind), 32'(got.result_kind));
        check_field("write_addr", 32'(want.write_addr), 32'(got.write_addr));
        check_field("write_byte", 32'(want.write_byte), 32'(got.write_byte));
        check_field("req_offset", want.req_offset, got.req_offset);
        check_field("req_length", 32'(want.req_length), 32'(got.req_length));
        check_field("file_size", want.file_size, got.file_size);
        check_field("received_count", 32'(want.received_count), 32'(got.received_count));
        check_field("error_code", 32'(want.error_code), 32'(got.error_code));
        check_field("last", 32'(want.last), 32'(got.last));
      end
    end
  end

  // Bound the run in case the block hangs.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: no progress after %0d cycles, %0d results outstanding",
             $time, cycles, expected_results.size());
    $display("firmware_block_reassembler: mismatch");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : run_tests
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = fbr_pkg::KIND_START;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    test_idle_block();
    test_requests_and_restart();
    test_message_handling();
    test_overlong_message();
    test_response_errors();
    test_file_end();
    // runs on the reset timeout, so it goes before any register write
    test_default_timeout();
    test_timeout_settings();
    test_backpressure();
    test_random_traffic();

    wait_drained();
    if (expected_results.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());

    $display("covered %0d input transfers (%0d acted on), %0d results checked",
             n_transfers, n_effective, n_results);
    $display("  %0d blocks completed, %0d ended in error, %0d timeouts", n_done, n_errors,
             n_timeouts);
    if (failures == 0 && expected_results.size() == 0) begin
      $display("firmware_block_reassembler: match");
    end else begin
      $display("firmware_block_reassembler: mismatch");
    end
    $finish;
  end

endmodule
